FILE: sv/cie_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and the fetch gap table for the copper instruction executor
package cie_pkg;

  localparam int ADDR_BITS = 21;
  localparam int ADDR_FIELD_BITS = 21;
  localparam int TIME_BITS = 18;
  localparam int NOW_BITS = 17;
  localparam int CAND_BITS = 19;
  localparam int XO_BITS = 9;

  localparam logic OP_EXECUTE = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  localparam logic [15:0] END_FIRST = 16'hffff;
  localparam logic [15:0] END_SECOND = 16'hfffe;
  localparam logic [8:0] DANGER_BASE = 9'h040;
  localparam logic [8:0] FREE_BASE = 9'h080;
  localparam logic [8:0] WRAP_LINE = 9'd255;
  localparam logic [7:0] WRAP_VPOS_MAX = 8'h40;
  localparam logic [7:0] VMASK_FORCE = 8'h80;
  localparam logic [4:0] AHEAD_OFFSET = 5'd20;
  localparam logic [4:0] WRAP_OFFSET = 5'd4;
  localparam logic [ADDR_BITS-1:0] PC_STEP = ADDR_BITS'(4);

  localparam logic RESET_DANGER_ENABLE = 1'b0;
  localparam logic [7:0] RESET_LINE_CYCLES = 8'd227;
  localparam logic [4:0] RESET_INSTRUCTION_INTERVAL = 5'd4;
  localparam logic [7:0] RESET_LOAD_START_DELAY = 8'd4;

  typedef enum logic [1:0] {
    CFG_DANGER_ENABLE        = 2'd0,
    CFG_LINE_CYCLES          = 2'd1,
    CFG_INSTRUCTION_INTERVAL = 2'd2,
    CFG_LOAD_START_DELAY     = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    TS_HALT,
    TS_PLAIN,
    TS_CHECK_WAIT,
    TS_CHECK_BLIT
  } time_sel_t;

  typedef struct packed {
    logic        operation;
    logic [15:0] first_word;
    logic [15:0] second_word;
    logic [8:0]  beam_line;
    logic [7:0]  beam_cycle;
    logic [3:0]  bitplane_mode;
    logic        blitter_busy;
    logic [17:0] blitter_done_time;
    logic [20:0] new_address;
  } item_t;

  typedef struct packed {
    logic        write_valid;
    logic [8:0]  write_register;
    logic [15:0] write_data;
    logic        next_valid;
    logic [17:0] next_time;
    logic [20:0] fetch_address;
  } result_t;

  typedef struct packed {
    logic                       write_valid;
    logic [8:0]                 write_register;
    logic [15:0]                write_data;
    time_sel_t                  sel;
    logic [NOW_BITS-1:0]        now;
    logic [7:0]                 addend;
    logic [NOW_BITS-1:0]        yprod;
    logic [XO_BITS-1:0]         xo;
    logic [CAND_BITS-1:0]       blit_time;
    logic [ADDR_FIELD_BITS-1:0] fetch_address;
  } mid_t;

  function automatic logic [4:0] fetch_gap(input logic [3:0] mode);
    logic [4:0] gap;
    unique case (mode)
      4'd5:    gap = 5'd5;
      4'd6:    gap = 5'd6;
      4'd11:   gap = 5'd8;
      4'd12:   gap = 5'd16;
      default: gap = 5'd4;
    endcase
    return gap;
  endfunction

endpackage

FILE: sv/copper_instruction_executor.sv
`timescale 1ns / 1ps
// copper instruction executor: move, wait and skip with program counter upkeep
// One instruction beat enters per clock unless item_stall is raised, and its result
// moves through the input, beam product and result registers. Both multiplications
// of a 9-bit line by line_cycles sit in the first stage; the second stage adds
// the offsets and compares the candidate fetch time against the current beam
// time. The program counter moves on as a beat leaves the input register, so
// back-to-back instructions see it in order. Configuration writes are always
// taken and must only be made while no beat is in flight.
module copper_instruction_executor (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  cie_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output cie_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [3:0]       cfg_index,
  input  logic [7:0]       cfg_data
);

  logic                           danger_enable;
  logic [7:0]                     line_cycles;
  logic [4:0]                     instruction_interval;
  logic [7:0]                     load_start_delay;
  logic [cie_pkg::ADDR_BITS-1:0]  pc;
  logic [cie_pkg::ADDR_BITS-1:0]  pc_next;

  cie_pkg::item_t   q;
  logic             q_valid;
  cie_pkg::mid_t    mid;
  cie_pkg::mid_t    mid_next;
  logic             mid_valid;
  cie_pkg::result_t res;
  cie_pkg::result_t res_next;
  logic             res_valid;

  logic res_free;
  logic mid_free;
  logic q_free;

  logic [8:0]                     y;
  logic [cie_pkg::NOW_BITS-1:0]   now;
  logic [cie_pkg::NOW_BITS-1:0]   yprod;

  assign res_free = !res_valid || !result_stall;
  assign mid_free = !mid_valid || res_free;
  assign q_free = !q_valid || mid_free;
  assign item_stall = !q_free;
  assign result_valid = res_valid;
  assign result = res;
  assign cfg_ready = 1'b1;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      danger_enable <= cie_pkg::RESET_DANGER_ENABLE;
      line_cycles <= cie_pkg::RESET_LINE_CYCLES;
      instruction_interval <= cie_pkg::RESET_INSTRUCTION_INTERVAL;
      load_start_delay <= cie_pkg::RESET_LOAD_START_DELAY;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == 4'(cie_pkg::CFG_DANGER_ENABLE)) begin
        danger_enable <= cfg_data[0];
      end
      if (cfg_index == 4'(cie_pkg::CFG_LINE_CYCLES)) begin
        line_cycles <= cfg_data;
      end
      if (cfg_index == 4'(cie_pkg::CFG_INSTRUCTION_INTERVAL)) begin
        instruction_interval <= cfg_data[4:0];
      end
      if (cfg_index == 4'(cie_pkg::CFG_LOAD_START_DELAY)) begin
        load_start_delay <= cfg_data;
      end
    end
  end

  // beam products
  assign now = cie_pkg::NOW_BITS'(q.beam_line) * cie_pkg::NOW_BITS'(line_cycles)
             + cie_pkg::NOW_BITS'(q.beam_cycle);
  assign yprod = cie_pkg::NOW_BITS'(y) * cie_pkg::NOW_BITS'(line_cycles);

  // decode and target selection
  always_comb begin
    logic [7:0]                    vmask;
    logic [7:0]                    vpos;
    logic [7:0]                    hpos;
    logic [7:0]                    hfree;
    logic [7:0]                    my;
    logic [7:0]                    mx;
    logic [7:0]                    x;
    logic [4:0]                    off;
    logic [8:0]                    wreg;
    logic                          passed;
    logic [cie_pkg::ADDR_BITS-1:0] pc_step;

    vmask = q.second_word[15:8] | cie_pkg::VMASK_FORCE;
    vpos = q.first_word[15:8];
    hpos = {q.first_word[7:1], 1'b0};
    hfree = {~q.second_word[7:1], 1'b0};
    my = q.beam_line[7:0] & vmask;
    mx = q.beam_cycle & q.second_word[7:0];
    wreg = {q.first_word[8:1], 1'b0};
    passed = (my > vpos) || ((my == vpos) && (mx >= hpos));
    pc_step = pc + cie_pkg::PC_STEP;

    y = '0;
    x = '0;
    off = '0;
    pc_next = pc;
    mid_next.write_valid = 1'b0;
    mid_next.write_register = '0;
    mid_next.write_data = '0;
    mid_next.sel = cie_pkg::TS_PLAIN;
    mid_next.addend = 8'(instruction_interval);
    mid_next.blit_time = cie_pkg::CAND_BITS'(q.blitter_done_time)
                       + cie_pkg::CAND_BITS'(instruction_interval);

    if (q.operation == cie_pkg::OP_LOAD) begin
      pc_next = cie_pkg::ADDR_BITS'(q.new_address);
      mid_next.addend = load_start_delay;
    end else begin
      pc_next = pc_step;
      if (q.first_word == cie_pkg::END_FIRST && q.second_word == cie_pkg::END_SECOND) begin
        mid_next.sel = cie_pkg::TS_HALT;
      end else if (!q.first_word[0]) begin
        if (wreg >= cie_pkg::FREE_BASE || (wreg >= cie_pkg::DANGER_BASE && danger_enable)) begin
          mid_next.write_valid = 1'b1;
          mid_next.write_register = wreg;
          mid_next.write_data = q.second_word;
          mid_next.addend = 8'(cie_pkg::fetch_gap(q.bitplane_mode));
        end else begin
          mid_next.sel = cie_pkg::TS_HALT;
        end
      end else if (!q.second_word[15] && q.blitter_busy) begin
        pc_next = pc;
        mid_next.sel = cie_pkg::TS_CHECK_BLIT;
      end else if (!q.second_word[0]) begin
        if (!passed) begin
          y = {q.beam_line[8], (q.beam_line[7:0] & ~vmask) | vpos};
          if (my == vpos && hfree < q.beam_cycle) begin
            x = (hfree & q.beam_cycle) | hpos;
          end else begin
            x = hpos;
          end
          off = cie_pkg::AHEAD_OFFSET;
          mid_next.sel = cie_pkg::TS_CHECK_WAIT;
          mid_next.addend = load_start_delay;
        end else if (q.beam_line == cie_pkg::WRAP_LINE && vpos <= cie_pkg::WRAP_VPOS_MAX) begin
          // line 255 wrap into the lines above 255
          y = {1'b1, ~vmask | vpos};
          x = hpos | (q.beam_cycle & hfree);
          off = cie_pkg::WRAP_OFFSET;
          mid_next.sel = cie_pkg::TS_CHECK_WAIT;
          mid_next.addend = load_start_delay;
        end
      end else if (passed) begin
        pc_next = pc_step + cie_pkg::PC_STEP;
      end
    end

    mid_next.now = now;
    mid_next.yprod = yprod;
    mid_next.xo = cie_pkg::XO_BITS'(x) + cie_pkg::XO_BITS'(off);
    mid_next.fetch_address = cie_pkg::ADDR_FIELD_BITS'(pc_next);
  end

  // fetch time
  always_comb begin
    logic [cie_pkg::TIME_BITS-1:0] fall;
    logic [cie_pkg::CAND_BITS-1:0] cand;
    logic                          later;

    fall = cie_pkg::TIME_BITS'(mid.now) + cie_pkg::TIME_BITS'(mid.addend);
    if (mid.sel == cie_pkg::TS_CHECK_BLIT) begin
      cand = mid.blit_time;
    end else begin
      cand = cie_pkg::CAND_BITS'(mid.yprod) + cie_pkg::CAND_BITS'(mid.xo);
    end
    later = cand > cie_pkg::CAND_BITS'(mid.now);

    res_next.write_valid = mid.write_valid;
    res_next.write_register = mid.write_register;
    res_next.write_data = mid.write_data;
    res_next.fetch_address = mid.fetch_address;
    res_next.next_valid = 1'b1;
    unique case (mid.sel)
      cie_pkg::TS_HALT: begin
        res_next.next_valid = 1'b0;
        res_next.next_time = '0;
      end
      cie_pkg::TS_PLAIN: begin
        res_next.next_time = fall;
      end
      cie_pkg::TS_CHECK_WAIT, cie_pkg::TS_CHECK_BLIT: begin
        res_next.next_time = later ? cie_pkg::TIME_BITS'(cand) : fall;
      end
      default: begin
        res_next.next_time = fall;
      end
    endcase
  end

  // pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
      mid_valid <= 1'b0;
      res_valid <= 1'b0;
      pc <= '0;
    end else begin
      if (q_free) begin
        q_valid <= item_valid;
      end
      if (mid_free) begin
        mid_valid <= q_valid;
        if (q_valid) begin
          pc <= pc_next;
        end
      end
      if (res_free) begin
        res_valid <= mid_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_free && item_valid) begin
      q <= item;
    end
    if (mid_free && q_valid) begin
      mid <= mid_next;
    end
    if (res_free && mid_valid) begin
      res <= res_next;
    end
  end

  a_halt_no_time: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.next_valid |-> result.next_time == '0)
    else $error("halted beat carries a fetch time");

  a_write_allowed: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.write_valid |->
      result.next_valid && result.write_register[8:6] != 3'd0 && !result.write_register[0])
    else $error("register write to a protected or odd offset");

  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.write_valid |->
      result.write_register == '0 && result.write_data == '0)
    else $error("idle write fields not cleared");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> q_valid)
    else $error("accepted beat lost at the input register");

  a_mid_holds: assert property (@(posedge clk) disable iff (rst)
    mid_valid && !res_free |=> mid_valid && $stable(mid))
    else $error("middle stage changed while the result was stalled");

endmodule
